// ===== hw/rtl/vrrb_pkg.sv =====
// ----------------------------------------------------------------------------
// vrrb_pkg
// Shared types and constants for the variable record ring buffer.
// ----------------------------------------------------------------------------
package vrrb_pkg;

    localparam int BUFFER_BYTES_DEF = 1024;
    localparam int HEADER_BYTES_DEF = 2;
    localparam int MAX_PAYLOAD_DEF  = 63;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 6;
    localparam int COUNT_W   = 10;
    localparam int HDR_CNT_W = 4;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;

    typedef enum logic [1:0] {
        MODE_ENQ   = 2'd0,
        MODE_DATA  = 2'd1,
        MODE_DEQ   = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_SEQ_ERR  = 2'd3
    } status_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic hdr_wr;
        logic rd_hdr;
        logic rd_pay;
        logic len_go;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic enq_go;
        logic deq_go;
        logic hdr_last;
        logic rd_done;
        logic len_zero;
    } sts_t;

endpackage

// ===== hw/rtl/vrrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// vrrb_ctrl
// Sequencer: takes one request at a time and steps the datapath through
// execute, header write, header read and payload read.
// ----------------------------------------------------------------------------
module vrrb_ctrl
    import vrrb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_HDR  = 6'b000100,
        S_RDH  = 6'b001000,
        S_LEN  = 6'b010000,
        S_PAY  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.out_free)
                begin
                    cmd.exec = 1'b1;
                    if (sts.enq_go)
                    begin
                        state_next = S_HDR;
                    end
                    else if (sts.deq_go)
                    begin
                        state_next = S_RDH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_HDR:
            begin
                cmd.hdr_wr = 1'b1;
                if (sts.hdr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RDH:
            begin
                cmd.rd_hdr = 1'b1;
                if (sts.rd_done)
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                if (!sts.len_zero)
                begin
                    cmd.len_go = 1'b1;
                    state_next = S_PAY;
                end
                else if (sts.out_free)
                begin
                    cmd.len_go = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_PAY:
            begin
                cmd.rd_pay = 1'b1;
                if (sts.rd_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/vrrb_dp.sv =====
// ----------------------------------------------------------------------------
// vrrb_dp
// Datapath: byte store, ring pointers, space checks, header decode and the
// result register.
// ----------------------------------------------------------------------------
module vrrb_dp
    import vrrb_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MAX_PAYLOAD  = MAX_PAYLOAD_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [1:0]        in_mode,
    input  logic [LEN_W-1:0]  in_length,
    input  logic [BYTE_W-1:0] in_byte,
    output logic              o_valid,
    input  logic              o_ready,
    output logic [1:0]        o_status,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_byte_valid,
    output logic [LEN_W-1:0]  o_length,
    output logic              o_last,
    output logic [COUNT_W-1:0] o_count
);

    localparam int OFF_W   = $clog2(BUFFER_BYTES + 1);
    localparam int ADDR_W  = $clog2(BUFFER_BYTES);
    localparam int CMP_W   = (OFF_W > 8) ? OFF_W : 8;
    localparam int CNT_RAW = $clog2(BUFFER_BYTES / HEADER_BYTES + 1);
    localparam int CNT_W   = (CNT_RAW > COUNT_W) ? CNT_RAW : COUNT_W;

    // byte store
    logic [BYTE_W-1:0] byte_store_reg [BUFFER_BYTES];
    logic [BYTE_W-1:0] rdata_reg;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [BYTE_W-1:0] mem_wdata;

    // latched request
    mode_t             mode_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [BYTE_W-1:0] data_reg;

    // ring state
    logic [OFF_W-1:0]  wo_reg, wo_next;
    logic [OFF_W-1:0]  ro_reg, ro_next;
    logic [OFF_W-1:0]  soft_end_reg, soft_end_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LEN_W-1:0]  pend_reg, pend_next;

    // sequencing
    logic [HDR_CNT_W-1:0] hk_reg, hk_next;
    logic [LEN_W-1:0]  iss_rem_reg, iss_rem_next;
    logic [LEN_W-1:0]  col_rem_reg, col_rem_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              rd_in_range_reg;
    logic [BYTE_W-1:0] b0_reg, b0_next;
    logic              big_reg, big_next;
    logic [LEN_W-1:0]  plen_reg, plen_next;

    // result register
    logic              o_valid_reg, o_valid_next;
    status_t           o_status_reg;
    logic [BYTE_W-1:0] o_byte_reg;
    logic              o_bvalid_reg;
    logic [LEN_W-1:0]  o_len_reg;
    logic              o_last_reg;
    logic [COUNT_W-1:0] o_count_reg;

    logic              push;
    status_t           p_status;
    logic [BYTE_W-1:0] p_byte;
    logic              p_bvalid;
    logic [LEN_W-1:0]  p_len;
    logic              p_last;

    logic              out_free;
    logic [CMP_W-1:0]  need;
    logic [CMP_W-1:0]  wo_c;
    logic [CMP_W-1:0]  ro_c;
    logic [CMP_W-1:0]  to_end;
    logic              enq_wrap;
    status_t           enq_status;
    status_t           deq_status;
    status_t           data_status;
    logic              wo_in_range;
    logic              ro_in_range;
    logic              consume;
    logic              issue;
    logic [BYTE_W-1:0] rd_byte;
    logic [LEN_W-1:0]  hdr_len;

    assign out_free    = !o_valid_reg || o_ready;
    assign wo_in_range = wo_reg < OFF_W'(BUFFER_BYTES);
    assign ro_in_range = ro_reg < OFF_W'(BUFFER_BYTES);
    assign rd_byte     = rd_in_range_reg ? rdata_reg : '0;
    assign hdr_len     = (big_reg || (b0_reg > BYTE_W'(MAX_PAYLOAD)))
                         ? LEN_W'(MAX_PAYLOAD) : b0_reg[LEN_W-1:0];

    // space, emptiness and sequence checks
    always_comb
    begin
        need       = CMP_W'(HEADER_BYTES) + CMP_W'(len_reg);
        wo_c       = CMP_W'(wo_reg);
        ro_c       = CMP_W'(ro_reg);
        to_end     = CMP_W'(BUFFER_BYTES) - wo_c;
        enq_wrap   = 1'b0;
        enq_status = ST_OK;
        if (pend_reg != '0)
        begin
            enq_status = ST_SEQ_ERR;
        end
        else if (len_reg > LEN_W'(MAX_PAYLOAD))
        begin
            enq_status = ST_NO_SPACE;
        end
        else if ((wo_reg == ro_reg) && (cnt_reg != '0))
        begin
            enq_status = ST_NO_SPACE;
        end
        else if (wo_c >= ro_c)
        begin
            if ((to_end < need) && (ro_c < need))
            begin
                enq_status = ST_NO_SPACE;
            end
            else
            begin
                enq_wrap = to_end < need;
            end
        end
        else if ((ro_c - wo_c) < need)
        begin
            enq_status = ST_NO_SPACE;
        end

        if (pend_reg != '0)
        begin
            deq_status = ST_SEQ_ERR;
        end
        else if (cnt_reg == '0)
        begin
            deq_status = ST_EMPTY;
        end
        else
        begin
            deq_status = ST_OK;
        end

        data_status = (pend_reg == '0) ? ST_SEQ_ERR : ST_OK;
    end

    assign consume = rd_valid_reg && (cmd.rd_hdr || (cmd.rd_pay && out_free));
    assign issue   = (cmd.rd_hdr || cmd.rd_pay) && (iss_rem_reg != '0)
                     && (!rd_valid_reg || consume);

    always_comb
    begin
        wo_next       = wo_reg;
        ro_next       = ro_reg;
        soft_end_next = soft_end_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        hk_next       = hk_reg;
        iss_rem_next  = iss_rem_reg;
        col_rem_next  = col_rem_reg;
        rd_valid_next = rd_valid_reg;
        b0_next       = b0_reg;
        big_next      = big_reg;
        plen_next     = plen_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_wdata     = data_reg;
        push          = 1'b0;
        p_status      = ST_OK;
        p_byte        = '0;
        p_bvalid      = 1'b0;
        p_len         = '0;
        p_last        = 1'b1;

        if (cmd.exec)
        begin
            unique case (mode_reg)
                MODE_ENQ:
                begin
                    push     = 1'b1;
                    p_status = enq_status;
                    if (enq_status == ST_OK)
                    begin
                        if (enq_wrap)
                        begin
                            soft_end_next = wo_reg;
                            wo_next       = '0;
                        end
                        cnt_next  = cnt_reg + CNT_W'(1);
                        pend_next = len_reg;
                        hk_next   = '0;
                    end
                end
                MODE_DATA:
                begin
                    push     = 1'b1;
                    p_status = data_status;
                    if (data_status == ST_OK)
                    begin
                        mem_we    = wo_in_range;
                        wo_next   = wo_reg + OFF_W'(1);
                        pend_next = pend_reg - LEN_W'(1);
                    end
                end
                MODE_CLEAR:
                begin
                    push          = 1'b1;
                    wo_next       = '0;
                    ro_next       = '0;
                    soft_end_next = OFF_W'(BUFFER_BYTES);
                    cnt_next      = '0;
                    pend_next     = '0;
                end
                MODE_DEQ:
                begin
                    if (deq_status == ST_OK)
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                        if (ro_reg == soft_end_reg)
                        begin
                            ro_next       = '0;
                            soft_end_next = OFF_W'(BUFFER_BYTES);
                        end
                        iss_rem_next = LEN_W'(HEADER_BYTES);
                        col_rem_next = LEN_W'(HEADER_BYTES);
                    end
                    else
                    begin
                        push     = 1'b1;
                        p_status = deq_status;
                    end
                end
            endcase
        end

        if (cmd.hdr_wr)
        begin
            mem_we    = wo_in_range;
            mem_wdata = (hk_reg == '0) ? BYTE_W'(len_reg) : '0;
            wo_next   = wo_reg + OFF_W'(1);
            hk_next   = hk_reg + HDR_CNT_W'(1);
        end

        if (issue)
        begin
            mem_re       = 1'b1;
            ro_next      = ro_reg + OFF_W'(1);
            iss_rem_next = iss_rem_reg - LEN_W'(1);
        end
        if (issue)
        begin
            rd_valid_next = 1'b1;
        end
        else if (consume)
        begin
            rd_valid_next = 1'b0;
        end

        if (consume)
        begin
            col_rem_next = col_rem_reg - LEN_W'(1);
            if (cmd.rd_hdr)
            begin
                if (col_rem_reg == LEN_W'(HEADER_BYTES))
                begin
                    b0_next  = rd_byte;
                    big_next = 1'b0;
                end
                else
                begin
                    big_next = big_reg || (rd_byte != '0);
                end
            end
            else
            begin
                push     = 1'b1;
                p_byte   = rd_byte;
                p_bvalid = 1'b1;
                p_len    = plen_reg;
                p_last   = col_rem_reg == LEN_W'(1);
            end
        end

        if (cmd.len_go)
        begin
            if (hdr_len == '0)
            begin
                push = 1'b1;
            end
            else
            begin
                plen_next    = hdr_len;
                iss_rem_next = hdr_len;
                col_rem_next = hdr_len;
            end
        end

        if (push)
        begin
            o_valid_next = 1'b1;
        end
        else if (o_ready)
        begin
            o_valid_next = 1'b0;
        end
        else
        begin
            o_valid_next = o_valid_reg;
        end
    end

    assign mem_addr = mem_re ? ro_reg[ADDR_W-1:0] : wo_reg[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            byte_store_reg[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= byte_store_reg[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wo_reg       <= '0;
            ro_reg       <= '0;
            soft_end_reg <= OFF_W'(BUFFER_BYTES);
            cnt_reg      <= '0;
            pend_reg     <= '0;
            hk_reg       <= '0;
            iss_rem_reg  <= '0;
            col_rem_reg  <= '0;
            rd_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            wo_reg       <= wo_next;
            ro_reg       <= ro_next;
            soft_end_reg <= soft_end_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            hk_reg       <= hk_next;
            iss_rem_reg  <= iss_rem_next;
            col_rem_reg  <= col_rem_next;
            rd_valid_reg <= rd_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode_t'(in_mode);
            len_reg  <= in_length;
            data_reg <= in_byte;
        end
        if (issue)
        begin
            rd_in_range_reg <= ro_in_range;
        end
        b0_reg   <= b0_next;
        big_reg  <= big_next;
        plen_reg <= plen_next;
        if (push)
        begin
            o_status_reg <= p_status;
            o_byte_reg   <= p_byte;
            o_bvalid_reg <= p_bvalid;
            o_len_reg    <= p_len;
            o_last_reg   <= p_last;
            o_count_reg  <= cnt_next[COUNT_W-1:0];
        end
    end

    assign o_valid      = o_valid_reg;
    assign o_status     = o_status_reg;
    assign o_byte       = o_byte_reg;
    assign o_byte_valid = o_bvalid_reg;
    assign o_length     = o_len_reg;
    assign o_last       = o_last_reg;
    assign o_count      = o_count_reg;

    assign sts.out_free = out_free;
    assign sts.enq_go   = (mode_reg == MODE_ENQ) && (enq_status == ST_OK);
    assign sts.deq_go   = (mode_reg == MODE_DEQ) && (deq_status == ST_OK);
    assign sts.hdr_last = hk_reg == HDR_CNT_W'(HEADER_BYTES - 1);
    assign sts.rd_done  = consume && (col_rem_reg == LEN_W'(1));
    assign sts.len_zero = hdr_len == '0;

`ifndef ASSERT_OFF
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("byte store written and read in one cycle");

    a_pend_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg != '0) |-> (cnt_reg != '0))
        else $error("payload pending with no record held");

    a_rd_track: assert property (@(posedge clk) disable iff (!rst_n)
        col_rem_reg == (iss_rem_reg + LEN_W'(rd_valid_reg)))
        else $error("read issue and collect counts out of step");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result pushed over a waiting result");
`endif

endmodule

// ===== hw/rtl/variable_record_ring_buffer_core.sv =====
// ----------------------------------------------------------------------------
// variable_record_ring_buffer_core
// Byte ring buffer of length-prefixed records with enqueue, payload, dequeue
// and clear requests on a streaming port.
// ----------------------------------------------------------------------------
// One request is taken at a time and runs through a single-port byte store.
// Clear, payload byte, and any rejected request: accept, then execute.
// Accepted enqueue: accept, execute, then one store write per header byte.
// Dequeue: accept, execute, one store read per header byte, a length check,
// then one store read per payload byte (none for a zero-length record), with
// results streamed one per cycle while the output is ready. A result waiting
// in the output register does not stop the next request being accepted.
// Store contents need no initialisation after reset.
module variable_record_ring_buffer_core
    import vrrb_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MAX_PAYLOAD  = MAX_PAYLOAD_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // record_length[5:0], data_byte[13:6]
    input  logic [S_TUSER_W-1:0] s_tuser,   // mode[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // status[1:0], out_byte[9:2],
                                            // out_length[15:10], record_count[25:16]
    output logic [M_TUSER_W-1:0] m_tuser,   // byte_valid[0]
    output logic                 m_tlast
);

    cmd_t               cmd;
    sts_t               sts;
    logic [1:0]         o_status;
    logic [BYTE_W-1:0]  o_byte;
    logic               o_byte_valid;
    logic [LEN_W-1:0]   o_length;
    logic [COUNT_W-1:0] o_count;

    vrrb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vrrb_dp #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_PAYLOAD  (MAX_PAYLOAD)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_mode      (s_tuser[1:0]),
        .in_length    (s_tdata[5:0]),
        .in_byte      (s_tdata[13:6]),
        .o_valid      (m_tvalid),
        .o_ready      (m_tready),
        .o_status     (o_status),
        .o_byte       (o_byte),
        .o_byte_valid (o_byte_valid),
        .o_length     (o_length),
        .o_last       (m_tlast),
        .o_count      (o_count)
    );

    assign m_tdata = {6'd0, o_count, o_length, o_byte, o_status};
    assign m_tuser = o_byte_valid;

endmodule

// ===== verif/variable_record_ring_buffer_core_tb.sv =====
// ----------------------------------------------------------------------------
// variable_record_ring_buffer_core_tb
// Self-checking bench for the record ring buffer: requests are streamed in
// with random gaps, every reply is checked field by field against a shadow
// copy of the store and its pointers kept inside the bench.
// ----------------------------------------------------------------------------
module variable_record_ring_buffer_core_tb;

    import vrrb_pkg::*;

    localparam int BUF   = BUFFER_BYTES_DEF;
    localparam int HDR   = HEADER_BYTES_DEF;
    localparam int MAXP  = MAX_PAYLOAD_DEF;
    localparam int DRAIN = HDR + MAXP + 16;

    typedef struct {
        bit          hold;
        mode_t       mode;
        logic [5:0]  len;
        logic [7:0]  data;
    } request_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic [5:0]  out_length;
        logic        last;
        logic [9:0]  count;
    } reply_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // record_length[5:0], data_byte[13:6]
    logic [S_TUSER_W-1:0] s_tuser;    // mode[1:0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // status[1:0], out_byte[9:2],
                                      // out_length[15:10], record_count[25:16]
    logic [M_TUSER_W-1:0] m_tuser;    // byte_valid[0]
    logic                 m_tlast;

    request_t pending_requests[$];
    reply_t   due_replies[$];
    int       replies_open;
    int       cyc;
    logic     may_idle;

    // shadow of the ring
    logic [7:0]  shadow_mem [0:BUF-1];
    logic [10:0] wr_ptr;
    logic [10:0] rd_ptr;
    logic [10:0] wrap_mark;
    logic [9:0]  held;
    logic [5:0]  owed;

    int n_requests;
    int n_replies;
    int n_bytes_out;
    int n_rejects;
    int n_wraps;
    int n_fail;

    variable_record_ring_buffer_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("FAIL variable_record_ring_buffer_core");
        $finish;
    end

    // ------------------------------------------------------------------ shadow
    function automatic logic [7:0] mem_get(int idx);
        if (idx < BUF)
            return shadow_mem[idx];
        return 8'h00;
    endfunction

    function automatic void mem_put(int idx, logic [7:0] v);
        if (idx < BUF)
            shadow_mem[idx] = v;
    endfunction

    task automatic ring_clear();
        wr_ptr    = '0;
        rd_ptr    = '0;
        wrap_mark = 11'(BUF);
        held      = '0;
        owed      = '0;
    endtask

    task automatic note_reply(status_t st, logic [7:0] b, logic v, logic [5:0] len,
                              logic lst);
        reply_t r;
        r.status     = st;
        r.out_byte   = b;
        r.byte_valid = v;
        r.out_length = len;
        r.last       = lst;
        r.count      = held;
        due_replies.push_back(r);
        if (st != ST_OK)
            n_rejects++;
    endtask

    function automatic status_t try_admit(logic [5:0] len);
        int need;
        int room_end;
        need = HDR + len;
        if (owed != 0)
            return ST_SEQ_ERR;
        if (len > MAXP)
            return ST_NO_SPACE;
        if (wr_ptr == rd_ptr && held != 0)
            return ST_NO_SPACE;
        if (wr_ptr >= rd_ptr)
        begin
            room_end = BUF - int'(wr_ptr);
            if (room_end < need && int'(rd_ptr) < need)
                return ST_NO_SPACE;
            if (room_end < need)
            begin
                wrap_mark = wr_ptr;
                wr_ptr    = '0;
                n_wraps++;
            end
        end
        else if (int'(rd_ptr) - int'(wr_ptr) < need)
            return ST_NO_SPACE;
        held++;
        for (int k = 0; k < HDR; k++)
            mem_put(int'(wr_ptr) + k, (k == 0) ? 8'(len) : 8'h00);
        wr_ptr = wr_ptr + 11'(HDR);
        owed   = len;
        return ST_OK;
    endfunction

    task automatic apply_request(mode_t mode, logic [5:0] len, logic [7:0] data);
        int hdr;
        int n;
        case (mode)
            MODE_ENQ:
                note_reply(try_admit(len), 8'h00, 1'b0, 6'd0, 1'b1);
            MODE_DATA:
                if (owed == 0)
                    note_reply(ST_SEQ_ERR, 8'h00, 1'b0, 6'd0, 1'b1);
                else
                begin
                    mem_put(int'(wr_ptr), data);
                    wr_ptr = wr_ptr + 11'd1;
                    owed   = owed - 6'd1;
                    note_reply(ST_OK, 8'h00, 1'b0, 6'd0, 1'b1);
                end
            MODE_CLEAR:
            begin
                ring_clear();
                note_reply(ST_OK, 8'h00, 1'b0, 6'd0, 1'b1);
            end
            default:
                if (owed != 0)
                    note_reply(ST_SEQ_ERR, 8'h00, 1'b0, 6'd0, 1'b1);
                else if (held == 0)
                    note_reply(ST_EMPTY, 8'h00, 1'b0, 6'd0, 1'b1);
                else
                begin
                    held--;
                    if (rd_ptr == wrap_mark)
                    begin
                        rd_ptr    = '0;
                        wrap_mark = 11'(BUF);
                    end
                    hdr = 0;
                    for (int k = 0; k < HDR; k++)
                        hdr |= int'(mem_get(int'(rd_ptr) + k)) << (8 * k);
                    n = (hdr > MAXP) ? MAXP : hdr;
                    rd_ptr = rd_ptr + 11'(HDR);
                    if (n == 0)
                        note_reply(ST_OK, 8'h00, 1'b0, 6'd0, 1'b1);
                    for (int k = 0; k < n; k++)
                        note_reply(ST_OK, mem_get(int'(rd_ptr) + k), 1'b1, 6'(n),
                                   k == n - 1);
                    rd_ptr = rd_ptr + 11'(n);
                end
        endcase
    endtask

    // --------------------------------------------------------------- stimulus
    task automatic push_req(mode_t m, logic [5:0] len, logic [7:0] data);
        request_t q;
        q.hold = 1'b0;
        q.mode = m;
        q.len  = len;
        q.data = data;
        pending_requests.push_back(q);
    endtask

    task automatic push_hold();
        request_t q;
        q.hold = 1'b1;
        q.mode = MODE_ENQ;
        q.len  = '0;
        q.data = '0;
        pending_requests.push_back(q);
    endtask

    task automatic push_noise_op(mode_t m);
        push_req(m, 6'($urandom), 8'($urandom));
    endtask

    // header then payload; a broken one gets a stray request placed after its header
    task automatic push_record(logic [5:0] len, bit broken);
        int cut;
        cut = broken ? $urandom_range(len) : -1;
        push_req(MODE_ENQ, len, 8'($urandom));
        for (int k = 0; k <= len; k++)
        begin
            if (k == cut)
                push_noise_op(($urandom_range(1) == 0) ? MODE_DEQ : MODE_ENQ);
            if (k < len)
                push_req(MODE_DATA, 6'($urandom), 8'($urandom));
        end
    endtask

    function automatic logic [5:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 6'($urandom_range(7));
        if (r < 90)
            return 6'($urandom_range(40, 8));
        return 6'(MAXP);
    endfunction

    // ----------------------------------------------------------------- driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= MODE_ENQ;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_requests.size() != 0 && pending_requests[0].hold)
            begin
                s_tvalid <= 1'b0;
                if (!s_tvalid && replies_open == 0)
                    void'(pending_requests.pop_front());
            end
            else if (pending_requests.size() != 0 &&
                     !(may_idle && $urandom_range(99) < 17))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, pending_requests[0].data, pending_requests[0].len};
                s_tuser  <= pending_requests[0].mode;
                void'(pending_requests.pop_front());
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !(may_idle && $urandom_range(99) < 17);
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cyc <= 0;
        else
            cyc <= cyc + 1;
    end

    // no stalls on either side through this window
    assign may_idle = !(cyc >= 100 && cyc < 300);

    // ---------------------------------------------------------------- monitor
    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            n_fail++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : monitor
        reply_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                apply_request(mode_t'(s_tuser), s_tdata[5:0], s_tdata[13:6]);
                n_requests++;
            end
            if (m_tvalid && m_tready)
            begin
                n_replies++;
                if (m_tuser[0])
                    n_bytes_out++;
                if (due_replies.size() == 0)
                begin
                    n_fail++;
                    $display("%0t: unexpected reply, expected none, actual %h/%b/%b",
                             $time, m_tdata, m_tuser, m_tlast);
                end
                else
                begin
                    want = due_replies.pop_front();
                    check_field("status", want.status, m_tdata[1:0]);
                    check_field("out_byte", want.out_byte, m_tdata[9:2]);
                    check_field("out_length", want.out_length, m_tdata[15:10]);
                    check_field("record_count", want.count, m_tdata[25:16]);
                    check_field("byte_valid", want.byte_valid, m_tuser[0]);
                    check_field("last", want.last, m_tlast);
                end
            end
            replies_open <= due_replies.size();
        end
    end

    // ------------------------------------------------------------------- main
    initial
    begin
        int         r;
        logic [5:0] plen;
        bit         half_done;
        rst_n        = 1'b0;
        replies_open = 0;
        n_requests   = 0;
        n_replies    = 0;
        n_bytes_out  = 0;
        n_rejects    = 0;
        n_wraps      = 0;
        n_fail       = 0;
        half_done    = 1'b0;
        for (int i = 0; i < BUF; i++)
            shadow_mem[i] = 8'h00;
        ring_clear();

        // directed: empty, stray byte, zero-length record, sequence errors
        push_req(MODE_DEQ, 6'd0, 8'h00);
        push_req(MODE_DATA, 6'd0, 8'hAA);
        push_req(MODE_ENQ, 6'd0, 8'h00);
        push_req(MODE_DEQ, 6'd0, 8'h00);
        push_req(MODE_ENQ, 6'd3, 8'h00);
        push_req(MODE_DATA, 6'd0, 8'hFF);
        push_req(MODE_ENQ, 6'd5, 8'h00);
        push_req(MODE_DEQ, 6'd0, 8'h00);
        push_req(MODE_DATA, 6'd0, 8'h00);
        push_req(MODE_DATA, 6'd0, 8'h55);
        push_req(MODE_DEQ, 6'd0, 8'h00);
        push_req(MODE_ENQ, 6'd1, 8'h00);
        push_req(MODE_DATA, 6'd0, 8'h80);
        push_req(MODE_CLEAR, 6'd0, 8'h00);
        push_req(MODE_DEQ, 6'd0, 8'h00);
        push_hold();

        // random: enqueue-heavy first half, dequeue-heavy second half
        while (pending_requests.size() < 118)
        begin
            r    = $urandom_range(99);
            plen = pick_length();
            if (!half_done && pending_requests.size() >= 70)
            begin
                push_hold();
                half_done = 1'b1;
            end
            if (int'(plen) + 3 > 120 - pending_requests.size())
                push_noise_op(MODE_DEQ);
            else if (r < (half_done ? 30 : 60))
                push_record(plen, 1'b0);
            else if (r < 80)
                push_noise_op(MODE_DEQ);
            else if (r < 88)
                push_noise_op(MODE_DATA);
            else if (r < 96 || !half_done)
                push_record(plen, 1'b1);
            else
                push_noise_op(MODE_CLEAR);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (pending_requests.size() != 0 || s_tvalid)
            @(negedge clk);
        while (due_replies.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("Run: %0d requests, %0d replies checked, %0d payload bytes read back",
                 n_requests, n_replies, n_bytes_out);
        $display("     %0d rejected requests, %0d write wraps, %0d mismatches",
                 n_rejects, n_wraps, n_fail);
        if (n_fail == 0)
            $display("PASS variable_record_ring_buffer_core");
        else
            $display("FAIL variable_record_ring_buffer_core");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/vrrb_pkg.sv
hw/rtl/vrrb_ctrl.sv
hw/rtl/vrrb_dp.sv
hw/rtl/variable_record_ring_buffer_core.sv
verif/variable_record_ring_buffer_core_tb.sv
